/* rtl/core/ubxp_pkg.sv */
package ubxp_pkg;

  // Frame framing bytes and the message that carries the navigation solution.
  localparam logic [7:0] SYNC_FIRST  = 8'hB5;
  localparam logic [7:0] SYNC_SECOND = 8'h62;
  localparam logic [7:0] NAV_CLASS   = 8'h01;
  localparam logic [7:0] PVT_ID      = 8'h07;

  // Lowest fix type that counts as a usable position.
  localparam logic [7:0] FIX_MIN_2D = 8'd2;

  // Number of captured payload bytes.
  localparam int CAPTURE_SLOTS = 22;

  // Reciprocals for exact unsigned 32-bit division by constants.
  // x / 10   == (x * RECIP_10)   >> 35
  // x / 1000 == (x * RECIP_1000) >> 38
  localparam logic [31:0] RECIP_10   = 32'hCCCC_CCCD;
  localparam logic [31:0] RECIP_1000 = 32'h1062_4DD3;

  // Frame status codes carried with each result.
  localparam logic [1:0] ST_PVT   = 2'd0;
  localparam logic [1:0] ST_OTHER = 2'd1;
  localparam logic [1:0] ST_FAIL  = 2'd2;

  typedef enum logic [8:0] {
    PH_HUNT    = 9'b000000001,
    PH_SYNC    = 9'b000000010,
    PH_CLASS   = 9'b000000100,
    PH_ID      = 9'b000001000,
    PH_LEN_LO  = 9'b000010000,
    PH_LEN_HI  = 9'b000100000,
    PH_PAYLOAD = 9'b001000000,
    PH_CK_A    = 9'b010000000,
    PH_CK_B    = 9'b100000000
  } phase_t;

  // Frame event as it leaves the parser: raw captured words.
  typedef struct packed {
    logic [1:0]  status;
    logic        take;
    logic        fix_ok;
    logic [7:0]  fix;
    logic [7:0]  sats;
    logic [31:0] lon;
    logic [30:0] lat;
    logic        alt_neg;
    logic [31:0] alt_mag;
    logic [31:0] speed;
    logic [31:0] heading;
  } event_t;

  // Frame event after scaling to the reported units.
  typedef struct packed {
    logic [1:0]  status;
    logic        take;
    logic        fix_ok;
    logic [7:0]  fix;
    logic [7:0]  sats;
    logic [31:0] lon;
    logic [30:0] lat;
    logic        alt_neg;
    logic [27:0] alt_q;
    logic [15:0] speed;
    logic [15:0] heading;
  } scaled_t;

endpackage

/* rtl/core/ubx_nav_pvt_frame_receiver_unit.sv */
// UBX frame receiver with NAV-PVT reporting.
//
// Input channel: one received serial byte per transaction on in_rx_byte,
// taken at a clock edge where in_valid is high and in_stall is low. The
// receiver hunts for the two sync bytes, follows class, id, length and
// payload, and checks the two 8-bit Fletcher checksum bytes, which cover
// class, id, both length bytes and the payload.
// Result channel: one transaction per finished frame (status 0 NAV-PVT
// accepted, 1 other valid frame) or per checksum mismatch (status 2). Each
// result carries the current report: fix type, satellite count, fix valid
// flag, position, altitude in cm, ground speed and heading.
// Throughput: one byte per cycle while in_stall is low; the frame parser
// handles each byte as it is taken. A result reaches out_valid from the
// checksum byte that causes it through the parser event register, the
// constant divide stage (multiply by reciprocal) and the output register.
// Stall: a held result keeps its fields stable. Bytes are still accepted
// while a result waits; in_stall rises only when the scaling stage holds a
// result behind a stalled output, and stays high while out_stall does.
// Reset: synchronous, active low. Parser returns to sync hunt; capture
// bytes and all report values clear to zero.
module ubx_nav_pvt_frame_receiver_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_rx_byte,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_status,
  output logic [7:0]         out_fix_kind,
  output logic [7:0]         out_satellites,
  output logic               out_fix_valid,
  output logic signed [30:0] out_latitude_e7,
  output logic signed [31:0] out_longitude_e7,
  output logic signed [28:0] out_altitude_cm,
  output logic [15:0]        out_ground_speed_cm,
  output logic [15:0]        out_heading_cdeg
);
  import ubxp_pkg::*;

  // Parser to scaling stage.
  logic    ev_valid;
  logic    ev_ready;
  event_t  ev;

  // Scaling stage to report and output register.
  logic    sc_valid;
  logic    sc_ready;
  scaled_t sc;

  ubxp_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .in_stall   (in_stall),
    .ev_ready   (ev_ready),
    .ev_valid   (ev_valid),
    .ev         (ev)
  );

  ubxp_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev       (ev),
    .ev_ready (ev_ready),
    .sc_ready (sc_ready),
    .sc_valid (sc_valid),
    .sc       (sc)
  );

  // The report values are updated in order as results reach the output,
  // so status 1 and 2 results always show the latest accepted report.
  ubxp_report u_report (
    .clk                 (clk),
    .rst_n               (rst_n),
    .sc_valid            (sc_valid),
    .sc                  (sc),
    .sc_ready            (sc_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_status    (out_frame_status),
    .out_fix_kind        (out_fix_kind),
    .out_satellites      (out_satellites),
    .out_fix_valid       (out_fix_valid),
    .out_latitude_e7     (out_latitude_e7),
    .out_longitude_e7    (out_longitude_e7),
    .out_altitude_cm     (out_altitude_cm),
    .out_ground_speed_cm (out_ground_speed_cm),
    .out_heading_cdeg    (out_heading_cdeg)
  );

endmodule

/* rtl/core/ubxp_parser.sv */
module ubxp_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [7:0]       in_rx_byte,
  output logic             in_stall,
  input  logic             ev_ready,
  output logic             ev_valid,
  output ubxp_pkg::event_t ev
);
  import ubxp_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  class_r, class_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] length_r, length_nxt;
  logic [15:0] count_r, count_nxt;
  logic [7:0]  sum_a_r, sum_a_nxt;
  logic [7:0]  sum_b_r, sum_b_nxt;
  logic [7:0]  cap_r [CAPTURE_SLOTS];

  logic        accept;
  logic [7:0]  sum_a_add, sum_b_add;
  logic [15:0] count_inc;
  logic        cap_hit;
  logic [4:0]  cap_slot;
  logic        fire;
  logic [1:0]  status;
  logic        take;
  logic [31:0] alt_word;

  logic    ev_valid_r;
  event_t  ev_r, ev_nxt;

  assign accept   = in_valid && ev_ready;
  assign in_stall = !ev_ready;

  assign sum_a_add = sum_a_r + in_rx_byte;
  assign sum_b_add = sum_b_r + sum_a_add;
  assign count_inc = count_r + 16'd1;

  // Map the payload offset to a capture slot.
  always_comb begin
    cap_hit  = 1'b1;
    cap_slot = '0;
    if (count_r == 16'd20) begin
      cap_slot = 5'd0;
    end else if (count_r == 16'd23) begin
      cap_slot = 5'd1;
    end else if (count_r >= 16'd24 && count_r <= 16'd31) begin
      cap_slot = 5'(count_r - 16'd22);
    end else if (count_r >= 16'd36 && count_r <= 16'd39) begin
      cap_slot = 5'(count_r - 16'd26);
    end else if (count_r >= 16'd60 && count_r <= 16'd67) begin
      cap_slot = 5'(count_r - 16'd46);
    end else begin
      cap_hit = 1'b0;
    end
  end

  always_comb begin
    phase_nxt  = phase_r;
    class_nxt  = class_r;
    id_nxt     = id_r;
    length_nxt = length_r;
    count_nxt  = count_r;
    sum_a_nxt  = sum_a_r;
    sum_b_nxt  = sum_b_r;
    fire       = 1'b0;
    status     = ST_FAIL;
    take       = 1'b0;
    unique case (phase_r)
      PH_SYNC: begin
        if (in_rx_byte == SYNC_SECOND) begin
          sum_a_nxt = '0;
          sum_b_nxt = '0;
          phase_nxt = PH_CLASS;
        end else begin
          phase_nxt = PH_HUNT;
        end
      end
      PH_CLASS: begin
        class_nxt = in_rx_byte;
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = in_rx_byte;
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_nxt = {8'd0, in_rx_byte};
        sum_a_nxt  = sum_a_add;
        sum_b_nxt  = sum_b_add;
        phase_nxt  = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        length_nxt = {in_rx_byte, length_r[7:0]};
        sum_a_nxt  = sum_a_add;
        sum_b_nxt  = sum_b_add;
        count_nxt  = '0;
        phase_nxt  = ({in_rx_byte, length_r[7:0]} == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        sum_a_nxt = sum_a_add;
        sum_b_nxt = sum_b_add;
        count_nxt = count_inc;
        if (count_inc == length_r) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        if (in_rx_byte == sum_a_r) begin
          phase_nxt = PH_CK_B;
        end else begin
          phase_nxt = PH_HUNT;
          fire      = 1'b1;
        end
      end
      PH_CK_B: begin
        phase_nxt = PH_HUNT;
        fire      = 1'b1;
        if (in_rx_byte == sum_b_r) begin
          if (class_r == NAV_CLASS && id_r == PVT_ID) begin
            status = ST_PVT;
            take   = 1'b1;
          end else begin
            status = ST_OTHER;
          end
        end
      end
      default: begin
        phase_nxt = (in_rx_byte == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
      end
    endcase
  end

  // The capture bytes do not change in the checksum phases, so the event
  // can be built straight from them.
  assign alt_word = {cap_r[13], cap_r[12], cap_r[11], cap_r[10]};

  always_comb begin
    ev_nxt.status  = status;
    ev_nxt.take    = take;
    ev_nxt.fix     = cap_r[0];
    ev_nxt.sats    = cap_r[1];
    ev_nxt.fix_ok  = (cap_r[0] >= FIX_MIN_2D);
    ev_nxt.lon     = {cap_r[5], cap_r[4], cap_r[3], cap_r[2]};
    ev_nxt.lat     = {cap_r[9][6:0], cap_r[8], cap_r[7], cap_r[6]};
    ev_nxt.alt_neg = alt_word[31];
    ev_nxt.alt_mag = alt_word[31] ? (~alt_word + 32'd1) : alt_word;
    ev_nxt.speed   = {cap_r[17], cap_r[16], cap_r[15], cap_r[14]};
    ev_nxt.heading = {cap_r[21], cap_r[20], cap_r[19], cap_r[18]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      class_r  <= '0;
      id_r     <= '0;
      length_r <= '0;
      count_r  <= '0;
      sum_a_r  <= '0;
      sum_b_r  <= '0;
      for (int i = 0; i < CAPTURE_SLOTS; i++) begin
        cap_r[i] <= '0;
      end
    end else if (accept) begin
      phase_r  <= phase_nxt;
      class_r  <= class_nxt;
      id_r     <= id_nxt;
      length_r <= length_nxt;
      count_r  <= count_nxt;
      sum_a_r  <= sum_a_nxt;
      sum_b_r  <= sum_b_nxt;
      if (phase_r == PH_PAYLOAD && cap_hit) begin
        cap_r[cap_slot] <= in_rx_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_valid_r <= 1'b0;
    end else if (ev_ready) begin
      ev_valid_r <= accept && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && accept && fire) begin
      ev_r <= ev_nxt;
    end
  end

  assign ev_valid = ev_valid_r;
  assign ev       = ev_r;

endmodule

/* rtl/core/ubxp_scale.sv */
module ubxp_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              ev_valid,
  input  ubxp_pkg::event_t  ev,
  output logic              ev_ready,
  input  logic              sc_ready,
  output logic              sc_valid,
  output ubxp_pkg::scaled_t sc
);
  import ubxp_pkg::*;

  logic [63:0] alt_prod;
  logic [63:0] speed_prod;
  logic [63:0] heading_prod;
  logic        sc_valid_r;
  scaled_t     sc_r, sc_nxt;

  // Each quotient is one 32 by 32 multiply against a fixed reciprocal.
  assign alt_prod     = {32'd0, ev.alt_mag} * {32'd0, RECIP_10};
  assign speed_prod   = {32'd0, ev.speed}   * {32'd0, RECIP_10};
  assign heading_prod = {32'd0, ev.heading} * {32'd0, RECIP_1000};

  always_comb begin
    sc_nxt.status  = ev.status;
    sc_nxt.take    = ev.take;
    sc_nxt.fix_ok  = ev.fix_ok;
    sc_nxt.fix     = ev.fix;
    sc_nxt.sats    = ev.sats;
    sc_nxt.lon     = ev.lon;
    sc_nxt.lat     = ev.lat;
    sc_nxt.alt_neg = ev.alt_neg;
    sc_nxt.alt_q   = alt_prod[62:35];
    sc_nxt.speed   = speed_prod[50:35];
    sc_nxt.heading = heading_prod[53:38];
  end

  assign ev_ready = !sc_valid_r || sc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sc_valid_r <= 1'b0;
    end else if (ev_ready) begin
      sc_valid_r <= ev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_ready && ev_valid) begin
      sc_r <= sc_nxt;
    end
  end

  assign sc_valid = sc_valid_r;
  assign sc       = sc_r;

endmodule

/* rtl/core/ubxp_report.sv */
module ubxp_report (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               sc_valid,
  input  ubxp_pkg::scaled_t  sc,
  output logic               sc_ready,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_frame_status,
  output logic [7:0]         out_fix_kind,
  output logic [7:0]         out_satellites,
  output logic               out_fix_valid,
  output logic signed [30:0] out_latitude_e7,
  output logic signed [31:0] out_longitude_e7,
  output logic signed [28:0] out_altitude_cm,
  output logic [15:0]        out_ground_speed_cm,
  output logic [15:0]        out_heading_cdeg
);
  import ubxp_pkg::*;

  logic        out_valid_r;
  logic [1:0]  status_r;
  logic [7:0]  fix_r;
  logic [7:0]  sats_r;
  logic        fix_valid_r;
  logic [30:0] lat_r;
  logic [31:0] lon_r;
  logic [28:0] alt_r;
  logic [15:0] speed_r;
  logic [15:0] heading_r;
  logic [28:0] alt_nxt;
  logic        load;

  assign sc_ready = !out_valid_r || !out_stall;
  assign load     = sc_ready && sc_valid;
  assign alt_nxt  = sc.alt_neg ? (29'd0 - {1'b0, sc.alt_q}) : {1'b0, sc.alt_q};

  // The report registers are the result payload; they only move when a
  // new result is loaded, so a stalled result holds still.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= ST_PVT;
      fix_r       <= '0;
      sats_r      <= '0;
      fix_valid_r <= 1'b0;
      lat_r       <= '0;
      lon_r       <= '0;
      alt_r       <= '0;
      speed_r     <= '0;
      heading_r   <= '0;
    end else if (sc_ready) begin
      out_valid_r <= sc_valid;
      if (sc_valid) begin
        status_r <= sc.status;
        if (sc.take) begin
          fix_r  <= sc.fix;
          sats_r <= sc.sats;
          if (sc.fix_ok) begin
            fix_valid_r <= 1'b1;
            lat_r       <= sc.lat;
            lon_r       <= sc.lon;
            alt_r       <= alt_nxt;
            speed_r     <= sc.speed;
            heading_r   <= sc.heading;
          end
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_frame_status    = status_r;
  assign out_fix_kind        = fix_r;
  assign out_satellites      = sats_r;
  assign out_fix_valid       = fix_valid_r;
  assign out_latitude_e7     = lat_r;
  assign out_longitude_e7    = lon_r;
  assign out_altitude_cm     = alt_r;
  assign out_ground_speed_cm = speed_r;
  assign out_heading_cdeg    = heading_r;

endmodule

/* rtl/core/ubxp_checker.sv */
module ubxp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic [7:0]         in_rx_byte,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_frame_status,
  input logic [7:0]         out_fix_kind,
  input logic [7:0]         out_satellites,
  input logic               out_fix_valid,
  input logic signed [30:0] out_latitude_e7,
  input logic signed [31:0] out_longitude_e7,
  input logic signed [28:0] out_altitude_cm,
  input logic [15:0]        out_ground_speed_cm,
  input logic [15:0]        out_heading_cdeg
);
  import ubxp_pkg::*;

  // Only the three defined status codes are ever reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_frame_status == ST_PVT || out_frame_status == ST_OTHER ||
                   out_frame_status == ST_FAIL))
    else $error("undefined frame status on result");

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_frame_status) &&
      $stable(out_fix_kind) && $stable(out_satellites) && $stable(out_fix_valid) &&
      $stable(out_latitude_e7) && $stable(out_longitude_e7) &&
      $stable(out_altitude_cm) && $stable(out_ground_speed_cm) &&
      $stable(out_heading_cdeg)))
    else $error("stalled result changed");

  // The fix valid flag is only cleared by reset.
  a_fix_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_fix_valid |=> out_fix_valid)
    else $error("fix valid flag dropped");

  // Without a usable fix the position report is still at its reset value.
  a_no_fix_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_fix_valid |-> (out_latitude_e7 == 31'sd0 && out_longitude_e7 == 32'sd0 &&
      out_altitude_cm == 29'sd0 && out_ground_speed_cm == 16'd0 &&
      out_heading_cdeg == 16'd0))
    else $error("position reported without a fix");

  // The input only backs up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while output is free");

endmodule

bind ubx_nav_pvt_frame_receiver_unit ubxp_checker u_checker (.*);

/* dv/tb_ubx_nav_pvt_frame_receiver_unit.sv */
`timescale 1ns / 100ps

module tb_ubx_nav_pvt_frame_receiver_unit;
  import ubxp_pkg::*;

  // One report as it leaves the receiver, at the port widths.
  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  fix;
    logic [7:0]  sats;
    logic        fix_valid;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [28:0] alt;
    logic [15:0] speed;
    logic [15:0] heading;
  } report_t;

  typedef logic [7:0] octets_t [$];

  // How a sent frame is spoiled on purpose.
  typedef enum int {DMG_NONE, DMG_CK_A, DMG_CK_B} damage_t;

  // Length and offsets of the NAV-PVT payload, and the total byte budget.
  localparam int PVT_LEN      = 68;
  localparam int OFF_FIX      = 20;
  localparam int OFF_SATS     = 23;
  localparam int OFF_LON      = 24;
  localparam int OFF_LAT      = 28;
  localparam int OFF_HEIGHT   = 36;
  localparam int OFF_SPEED    = 60;
  localparam int OFF_HEADING  = 64;
  localparam int TOTAL_BYTES  = 1450;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic [7:0]  in_rx_byte;
  logic        in_stall;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_frame_status;
  logic [7:0]  out_fix_kind;
  logic [7:0]  out_satellites;
  logic        out_fix_valid;
  logic signed [30:0] out_latitude_e7;
  logic signed [31:0] out_longitude_e7;
  logic signed [28:0] out_altitude_cm;
  logic [15:0] out_ground_speed_cm;
  logic [15:0] out_heading_cdeg;

  ubx_nav_pvt_frame_receiver_unit DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_rx_byte          (in_rx_byte),
    .in_stall            (in_stall),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_frame_status    (out_frame_status),
    .out_fix_kind        (out_fix_kind),
    .out_satellites      (out_satellites),
    .out_fix_valid       (out_fix_valid),
    .out_latitude_e7     (out_latitude_e7),
    .out_longitude_e7    (out_longitude_e7),
    .out_altitude_cm     (out_altitude_cm),
    .out_ground_speed_cm (out_ground_speed_cm),
    .out_heading_cdeg    (out_heading_cdeg)
  );

  // ---------------------------------------------------------------------
  // Frame tracker: a cycle-free copy of what the receiver should do with
  // each accepted byte. It follows the frame phases, keeps the running
  // Fletcher sums, captures the payload bytes it cares about and holds the
  // current report. Every result it predicts is queued in pending_reports.
  // ---------------------------------------------------------------------
  phase_t      rx_phase;
  logic [7:0]  hdr_class;
  logic [7:0]  hdr_id;
  logic [15:0] pay_len;
  logic [15:0] pay_idx;
  logic [7:0]  fl_a;
  logic [7:0]  fl_b;
  logic [7:0]  cap_bytes [0:CAPTURE_SLOTS-1];
  logic [7:0]  rep_fix;
  logic [7:0]  rep_sats;
  logic        rep_fix_valid;
  logic [31:0] rep_lat;
  logic [31:0] rep_lon;
  logic [31:0] rep_alt;
  logic [15:0] rep_speed;
  logic [15:0] rep_heading;

  report_t pending_reports [$];

  // Counters for the summary and the verdict.
  int mismatches;
  int reports_checked;
  int pvt_reports;
  int other_reports;
  int fail_reports;
  int frame_bytes;
  int bytes_sent;

  // Sender burst state, and a scratch payload shared by the frame builders.
  int      burst_left;
  octets_t pay_buf;

  task automatic clear_tracker();
    rx_phase      = PH_HUNT;
    hdr_class     = '0;
    hdr_id        = '0;
    pay_len       = '0;
    pay_idx       = '0;
    fl_a          = '0;
    fl_b          = '0;
    for (int i = 0; i < CAPTURE_SLOTS; i++) cap_bytes[i] = '0;
    rep_fix       = '0;
    rep_sats      = '0;
    rep_fix_valid = 1'b0;
    rep_lat       = '0;
    rep_lon       = '0;
    rep_alt       = '0;
    rep_speed     = '0;
    rep_heading   = '0;
  endtask

  // Where a payload offset lands in the capture store, or -1 if it is not kept.
  function automatic int cap_slot(input logic [15:0] off);
    if (off == OFF_FIX) return 0;
    if (off == OFF_SATS) return 1;
    if (off >= OFF_LON && off < OFF_LAT + 4) return 2 + int'(off) - OFF_LON;
    if (off >= OFF_HEIGHT && off < OFF_HEIGHT + 4) return 10 + int'(off) - OFF_HEIGHT;
    if (off >= OFF_SPEED && off < OFF_HEADING + 4) return 14 + int'(off) - OFF_SPEED;
    return -1;
  endfunction

  function automatic logic [31:0] cap_word(input int s);
    return {cap_bytes[s+3], cap_bytes[s+2], cap_bytes[s+1], cap_bytes[s]};
  endfunction

  task automatic fold_sum(input logic [7:0] b);
    fl_a = fl_a + b;
    fl_b = fl_b + fl_a;
  endtask

  task automatic post_report(input logic [1:0] st);
    report_t r;
    r.status    = st;
    r.fix       = rep_fix;
    r.sats      = rep_sats;
    r.fix_valid = rep_fix_valid;
    r.lat       = rep_lat[30:0];
    r.lon       = rep_lon;
    r.alt       = rep_alt[28:0];
    r.speed     = rep_speed;
    r.heading   = rep_heading;
    pending_reports.push_back(r);
    case (st)
      ST_PVT:   pvt_reports++;
      ST_OTHER: other_reports++;
      default:  fail_reports++;
    endcase
  endtask

  // A checked NAV-PVT always refreshes fix type and satellite count; the
  // position block only moves once the fix is at least 2D. Height is a
  // signed division that truncates toward zero.
  task automatic take_position();
    int alt_q;
    rep_fix  = cap_bytes[0];
    rep_sats = cap_bytes[1];
    if (cap_bytes[0] >= FIX_MIN_2D) begin
      alt_q         = $signed(cap_word(10)) / 10;
      rep_fix_valid = 1'b1;
      rep_lon       = cap_word(2);
      rep_lat       = cap_word(6);
      rep_alt       = alt_q;
      rep_speed     = 16'(cap_word(14) / 32'd10);
      rep_heading   = 16'(cap_word(18) / 32'd1000);
    end
  endtask

  task automatic track_byte(input logic [7:0] b);
    int s;
    case (rx_phase)
      PH_SYNC: begin
        // A wrong second sync byte drops back to the hunt without a recheck.
        if (b == SYNC_SECOND) begin
          fl_a     = '0;
          fl_b     = '0;
          rx_phase = PH_CLASS;
        end else begin
          rx_phase = PH_HUNT;
        end
      end
      PH_CLASS: begin
        hdr_class = b;
        fold_sum(b);
        rx_phase  = PH_ID;
      end
      PH_ID: begin
        hdr_id   = b;
        fold_sum(b);
        rx_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        pay_len  = {8'h00, b};
        fold_sum(b);
        rx_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        pay_len[15:8] = b;
        fold_sum(b);
        pay_idx  = '0;
        rx_phase = (pay_len == 16'd0) ? PH_CK_A : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        s = cap_slot(pay_idx);
        if (s >= 0) cap_bytes[s] = b;
        fold_sum(b);
        pay_idx = pay_idx + 16'd1;
        if (pay_idx == pay_len) rx_phase = PH_CK_A;
      end
      PH_CK_A: begin
        if (b == fl_a) begin
          rx_phase = PH_CK_B;
        end else begin
          rx_phase = PH_HUNT;
          post_report(ST_FAIL);
        end
      end
      PH_CK_B: begin
        rx_phase = PH_HUNT;
        if (b != fl_b) begin
          post_report(ST_FAIL);
        end else if (hdr_class == NAV_CLASS && hdr_id == PVT_ID) begin
          take_position();
          post_report(ST_PVT);
        end else begin
          post_report(ST_OTHER);
        end
      end
      default: begin
        rx_phase = (b == SYNC_FIRST) ? PH_SYNC : PH_HUNT;
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Clock, limit and receiver stall pattern.
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Worst case is about fifteen hundred bytes, each held off by long output
  // stalls and sender gaps; 2 ms is far beyond any correct run.
  initial begin
    #2_000_000;
    $display("** ubx_nav_pvt_frame_receiver_unit: FAILED **");
    $finish;
  end

  // The receiver switches among three moods: never stall, stall at random
  // on about a third of the cycles, and long stall runs that push back far
  // enough to raise in_stall. Each mood lasts a random stretch.
  initial begin : stall_gen
    int mood;
    int mood_left;
    int run_left;
    logic run_level;
    mood      = 0;
    mood_left = 0;
    run_left  = 0;
    run_level = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (mood_left == 0) begin
        mood      = $urandom_range(0, 2);
        mood_left = $urandom_range(64, 256);
      end
      mood_left--;
      if (mood == 2 && run_left == 0) begin
        run_level = ~run_level;
        run_left  = run_level ? $urandom_range(3, 30) : $urandom_range(1, 12);
      end
      if (run_left > 0) run_left--;
      case (mood)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 2) == 0);
        default: out_stall <= run_level;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Result checker. Outputs are sampled at the rising edge; a transaction
  // completes where out_valid is high and out_stall is low. Each one is
  // matched against the oldest predicted report, field by field.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    report_t got;
    report_t want;
    logic    bad;
    if (rst_n && out_valid && !out_stall) begin
      got.status    = out_frame_status;
      got.fix       = out_fix_kind;
      got.sats      = out_satellites;
      got.fix_valid = out_fix_valid;
      got.lat       = out_latitude_e7;
      got.lon       = out_longitude_e7;
      got.alt       = out_altitude_cm;
      got.speed     = out_ground_speed_cm;
      got.heading   = out_heading_cdeg;
      if (pending_reports.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result with nothing expected: status %0d fix %0d sats %0d",
                   $realtime, got.status, got.fix, got.sats);
        mismatches++;
      end else begin
        want = pending_reports.pop_front();
        reports_checked++;
        bad = (got.status !== want.status) || (got.fix !== want.fix) ||
              (got.sats !== want.sats) || (got.fix_valid !== want.fix_valid) ||
              (got.lat !== want.lat) || (got.lon !== want.lon) ||
              (got.alt !== want.alt) || (got.speed !== want.speed) ||
              (got.heading !== want.heading);
        if (bad) begin
          if (mismatches < 10) begin
            $display("%0t: report %0d mismatch", $realtime, reports_checked);
            $display("  exp st %0d fix %0d sats %0d ok %0d lat %h lon %h alt %h spd %h hdg %h",
                     want.status, want.fix, want.sats, want.fix_valid, want.lat,
                     want.lon, want.alt, want.speed, want.heading);
            $display("  got st %0d fix %0d sats %0d ok %0d lat %h lon %h alt %h spd %h hdg %h",
                     got.status, got.fix, got.sats, got.fix_valid, got.lat,
                     got.lon, got.alt, got.speed, got.heading);
          end
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------

  // Sends one byte as one transaction. The sender runs in bursts; between
  // bursts in_valid drops for a random gap, sometimes none at all so that
  // back-to-back stretches occur. The byte is handed to the frame tracker
  // at the edge where the receiver takes it.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      case ($urandom_range(0, 15))
        0, 1, 2, 3, 4: gap = 0;
        5:             gap = $urandom_range(10, 25);
        default:       gap = $urandom_range(1, 5);
      endcase
      repeat (gap) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
    track_byte(b);
  endtask

  // Wraps pay_buf in sync, header and checksum. A damaged frame gets one
  // of its two checksum bytes altered by a nonzero pattern.
  task automatic send_frame(input logic [7:0] cls, input logic [7:0] id,
                            input damage_t damage);
    logic [7:0]  ck_a;
    logic [7:0]  ck_b;
    logic [15:0] len;
    octets_t     covered;
    len     = 16'(pay_buf.size());
    covered = {cls, id, len[7:0], len[15:8]};
    ck_a    = '0;
    ck_b    = '0;
    foreach (pay_buf[i]) covered.push_back(pay_buf[i]);
    foreach (covered[i]) begin
      ck_a = ck_a + covered[i];
      ck_b = ck_b + ck_a;
    end
    if (damage == DMG_CK_A) ck_a ^= 8'($urandom_range(1, 255));
    if (damage == DMG_CK_B) ck_b ^= 8'($urandom_range(1, 255));
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (covered[i]) send_byte(covered[i]);
    send_byte(ck_a);
    send_byte(ck_b);
    frame_bytes += covered.size() + 4;
  endtask

  task automatic fill_random(input int len);
    pay_buf.delete();
    repeat (len) pay_buf.push_back(8'($urandom));
  endtask

  // Places a little-endian word at a payload offset, clipped to the length.
  task automatic put_word(input int off, input logic [31:0] w);
    for (int k = 0; k < 4; k++)
      if (off + k < pay_buf.size()) pay_buf[off + k] = w[8*k +: 8];
  endtask

  // Builds a NAV-PVT payload of any length; fields that fall past the end
  // are simply not sent.
  task automatic build_pvt(input int len, input logic [7:0] fix, input logic [7:0] sats,
                           input logic [31:0] lon, input logic [31:0] lat,
                           input logic [31:0] height, input logic [31:0] speed,
                           input logic [31:0] heading);
    fill_random(len);
    if (OFF_FIX < len) pay_buf[OFF_FIX] = fix;
    if (OFF_SATS < len) pay_buf[OFF_SATS] = sats;
    put_word(OFF_LON, lon);
    put_word(OFF_LAT, lat);
    put_word(OFF_HEIGHT, height);
    put_word(OFF_SPEED, speed);
    put_word(OFF_HEADING, heading);
  endtask

  // Random word that lands on an extreme value one time in two.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------

  // Sync hunting: a doubled first sync byte, a wrong second sync byte and
  // loose noise must all be ignored, then a clean frame is still found.
  task automatic test_sync_hunt();
    send_byte(SYNC_FIRST);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(8'h00);
    send_byte(8'h11);
    send_byte(SYNC_FIRST);
    send_byte(8'h63);
    send_byte(8'hFF);
    fill_random(2);
    send_frame(8'h0A, 8'h04, DMG_NONE);
  endtask

  // Zero-length frames skip straight to the checksum. An empty NAV-PVT
  // reports whatever was captured before, which is zero after reset.
  task automatic test_empty_frames();
    pay_buf.delete();
    send_frame(8'h05, 8'h01, DMG_NONE);
    pay_buf.delete();
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
  endtask

  // A bad CK_A fails at once and the next byte is hunted again; a bad CK_B
  // fails after both bytes. A spoiled NAV-PVT must not move the report.
  task automatic test_checksum_errors();
    fill_random(3);
    send_frame(8'h06, 8'h00, DMG_CK_A);
    fill_random(1);
    send_frame(8'h0B, 8'h30, DMG_CK_B);
    build_pvt(PVT_LEN, 8'd3, 8'd12, 32'h1234_5678, 32'h0765_4321, 32'd100_000,
              32'd5000, 32'd9_000_000);
    send_frame(NAV_CLASS, PVT_ID, DMG_CK_B);
    pay_buf.delete();
    send_frame(8'h0A, 8'h04, DMG_NONE);
  endtask

  // NAV-PVT content: extreme fields, the fix threshold, height rounding
  // toward zero, a short frame that only reaches fix and satellites, a
  // long frame with a nonzero high length byte, and near-miss class/id.
  task automatic test_nav_pvt_fields();
    build_pvt(PVT_LEN, 8'hFF, 8'hFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(PVT_LEN, 8'd1, 8'd4, 32'h1111_1111, 32'h2222_2222, 32'd7,
              32'd70, 32'd7000);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(PVT_LEN, FIX_MIN_2D, 8'd0, 32'h0, 32'hFFFF_FFFF, -32'sd9,
              32'd9, 32'd999);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(PVT_LEN, 8'd3, 8'd9, 32'h7FFF_FFFF, 32'h8000_0000, -32'sd10,
              32'd10, 32'd1000);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(PVT_LEN, 8'd4, 8'd20, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'h7FFF_FFFF,
              32'd655_359, 32'd65_535_999);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(24, 8'd5, 8'd33, '0, '0, '0, '0, '0);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    build_pvt(300, 8'd2, 8'd7, 32'h0102_0304, 32'h0506_0708, -32'sd123_456,
              32'd123_456, 32'd36_000_000);
    send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
    fill_random(4);
    send_frame(NAV_CLASS, 8'h06, DMG_NONE);
    fill_random(4);
    send_frame(8'h02, PVT_ID, DMG_NONE);
  endtask

  // Random traffic: mostly well-formed frames with random content, some
  // spoiled checksums, loose noise and frames cut off mid-payload. It runs
  // until the whole test has sent its share of bytes.
  task automatic test_random_stream();
    int   pick;
    int   len;
    int   cut;
    logic [7:0] fix;
    logic [15:0] short_len;
    while (bytes_sent < TOTAL_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 9))
          0:       len = $urandom_range(0, PVT_LEN - 1);
          1:       len = $urandom_range(PVT_LEN + 9, 120);
          default: len = $urandom_range(PVT_LEN, PVT_LEN + 8);
        endcase
        fix = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
        build_pvt(len, fix, 8'($urandom), pick_word(), pick_word(), pick_word(),
                  pick_word(), pick_word());
        case ($urandom_range(0, 9))
          0:       send_frame(NAV_CLASS, PVT_ID, DMG_CK_A);
          1:       send_frame(NAV_CLASS, PVT_ID, DMG_CK_B);
          default: send_frame(NAV_CLASS, PVT_ID, DMG_NONE);
        endcase
      end else if (pick < 75) begin
        fill_random($urandom_range(0, 16));
        case ($urandom_range(0, 13))
          0:       send_frame(8'($urandom), 8'($urandom), DMG_CK_A);
          1:       send_frame(8'($urandom), 8'($urandom), DMG_CK_B);
          default: send_frame(8'($urandom), 8'($urandom), DMG_NONE);
        endcase
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        if ($urandom_range(0, 1) == 0) begin
          send_byte(SYNC_FIRST);
          send_byte(8'($urandom_range(0, 255)) ^ 8'h01);
        end
      end else begin
        // Header announces a short payload, then the frame is cut short;
        // whatever follows is taken as payload and checksum.
        short_len = 16'($urandom_range(1, 10));
        cut       = $urandom_range(0, short_len - 1);
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
        send_byte(short_len[7:0]);
        send_byte(short_len[15:8]);
        repeat (cut) send_byte(8'($urandom));
        frame_bytes += 6 + cut;
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_rx_byte      = '0;
    mismatches      = 0;
    reports_checked = 0;
    pvt_reports     = 0;
    other_reports   = 0;
    fail_reports    = 0;
    frame_bytes     = 0;
    bytes_sent      = 0;
    burst_left      = 0;
    clear_tracker();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_sync_hunt();
    test_empty_frames();
    test_checksum_errors();
    test_nav_pvt_fields();
    test_random_stream();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    // Results pass the parser event, scaling and output registers; allow a
    // margin for any stray transaction that should not be there.
    repeat (20) @(posedge clk);

    $display("Checked %0d reports over %0d bytes (%0d in frames): %0d NAV-PVT,",
             reports_checked, bytes_sent, frame_bytes, pvt_reports);
    $display("%0d other, %0d bad sum; mismatches: %0d, reports still outstanding: %0d.",
             other_reports, fail_reports, mismatches, pending_reports.size());
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("** ubx_nav_pvt_frame_receiver_unit: PASSED **");
    end else begin
      $display("** ubx_nav_pvt_frame_receiver_unit: FAILED **");
    end
    $finish;
  end

endmodule
